>>> rtl/mean_luma_binarizer_core_defines.svh
// Assertion macros used by the mean luma binarizer controller.
`ifndef MEAN_LUMA_BINARIZER_CORE_DEFINES_SVH
`define MEAN_LUMA_BINARIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlb_pkg.sv
`timescale 1ns / 1ps

package mlb_pkg;

    // Frame geometry
    localparam int FRAME_PIXELS = 76800;
    localparam int LINE_PIXELS  = 320;

    // Field and state widths
    localparam int PIXEL_W = 16;
    localparam int LUMA_W  = 15;
    localparam int FRAC_W  = 10;
    localparam int LEVEL_W = 5;
    localparam int BIAS_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int SUM_W   = 22;
    localparam int COL_W   = $clog2(LINE_PIXELS);

    // Highest level the mean can report
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;

    // Luma weights in Q.10
    localparam int COEF_R = 306;
    localparam int COEF_G = 601;
    localparam int COEF_B = 117;

    // Controller to datapath commands
    typedef struct packed {
        logic measure;
        logic bin_live;
        logic level_load;
        logic bin_held;
    } mlb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_binarize;
    } mlb_stat_t;

    // Weighted luma of an RGB565 pixel in Q.10, green taken from its top five bits
    function automatic logic [LUMA_W-1:0] luma_q10(input logic [PIXEL_W-1:0] px);
        logic [LUMA_W-1:0] r;
        logic [LUMA_W-1:0] g;
        logic [LUMA_W-1:0] b;
        r = LUMA_W'(px[15:11]);
        g = LUMA_W'(px[10:6]);
        b = LUMA_W'(px[4:0]);
        return r * LUMA_W'(COEF_R) + g * LUMA_W'(COEF_G) + b * LUMA_W'(COEF_B);
    endfunction

endpackage

>>> rtl/mlb_dpath.sv
`timescale 1ns / 1ps

module mlb_dpath
    import mlb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mlb_cmd_t            cmd,
    output mlb_stat_t           stat,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                threshold_bias_we,
    input  logic [BIAS_W-1:0]   threshold_bias_wdata,
    output logic                done,
    output logic                white,
    output logic [BYTE_W-1:0]   packed_byte,
    output logic                byte_ready,
    output logic [LEVEL_W-1:0]  level
);

    logic [BIAS_W-1:0]  bias_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [BYTE_W-1:0]  partial_reg;
    logic [COL_W-1:0]   column_reg;
    logic               in_bin_reg;
    logic               done_reg;
    logic [PIXEL_W-1:0] hold_reg;
    logic               white_reg;
    logic [BYTE_W-1:0]  packed_reg;
    logic               ready_reg;
    logic [LEVEL_W-1:0] level_out_reg;

    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   sum_base;
    logic [SUM_W:0]     sum_wide;
    logic [LUMA_W-1:0]  luma_live;
    logic [LUMA_W-1:0]  luma_bin;
    logic [LEVEL_W-1:0] level_calc;
    logic [LEVEL_W:0]   level_biased;
    logic [LUMA_W:0]    thresh;
    logic               white_next;
    logic [SLOT_W-1:0]  slot;
    logic [BYTE_W-1:0]  packed_next;
    logic               ready_next;
    logic               bin_any;

    // Measure: add the integer luma to the sum, restart it on a new pass, saturate
    assign luma_live = luma_q10(pixel);
    assign sum_base  = in_bin_reg ? '0 : sum_reg;
    assign sum_wide  = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(luma_live[LUMA_W-1:FRAC_W]);
    assign sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    // Level: count the whole frames held in the sum, stopping at the top level
    always_comb
    begin
        level_calc = '0;
        for (int k = 1; k <= LEVEL_MAX; k++)
        begin
            if (64'(sum_reg) >= 64'(k) * 64'(FRAME_PIXELS))
            begin
                level_calc = LEVEL_W'(k);
            end
        end
    end

    // Binarize: strict compare of luma against (level + bias) in Q.10
    assign bin_any      = cmd.bin_live || cmd.bin_held;
    assign luma_bin     = cmd.bin_held ? luma_q10(hold_reg) : luma_live;
    assign level_biased = (LEVEL_W + 1)'(level_reg) + (LEVEL_W + 1)'(bias_reg);
    assign thresh       = {level_biased, {FRAC_W{1'b0}}};
    assign white_next   = (LUMA_W + 1)'(luma_bin) > thresh;
    assign slot         = column_reg[SLOT_W-1:0];
    assign packed_next  = partial_reg | (BYTE_W'(white_next) << slot);
    assign ready_next   = slot == SLOT_W'(BYTE_W - 1);

    // Hold control state and the sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg    <= BIAS_W'(1);
            sum_reg     <= '0;
            level_reg   <= '0;
            partial_reg <= '0;
            column_reg  <= '0;
            in_bin_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= bin_any;
            if (threshold_bias_we)
            begin
                bias_reg <= threshold_bias_wdata;
            end
            if (cmd.measure)
            begin
                sum_reg <= sum_next;
                if (in_bin_reg)
                begin
                    in_bin_reg  <= 1'b0;
                    partial_reg <= '0;
                    column_reg  <= '0;
                end
            end
            if (cmd.level_load)
            begin
                in_bin_reg  <= 1'b1;
                level_reg   <= level_calc;
                partial_reg <= '0;
                column_reg  <= '0;
            end
            if (bin_any)
            begin
                partial_reg <= ready_next ? '0 : packed_next;
                if (column_reg == COL_W'(LINE_PIXELS - 1))
                begin
                    column_reg <= '0;
                end
                else
                begin
                    column_reg <= column_reg + COL_W'(1);
                end
            end
        end
    end

    // Hold the waiting pixel and the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.level_load)
        begin
            hold_reg <= pixel;
        end
        if (bin_any)
        begin
            white_reg     <= white_next;
            packed_reg    <= packed_next;
            ready_reg     <= ready_next;
            level_out_reg <= level_reg;
        end
    end

    assign stat.in_binarize = in_bin_reg;
    assign done        = done_reg;
    assign white       = white_reg;
    assign packed_byte = packed_reg;
    assign byte_ready  = ready_reg;
    assign level       = level_out_reg;

endmodule

>>> rtl/mlb_ctrl.sv
`timescale 1ns / 1ps
`include "mean_luma_binarizer_core_defines.svh"

module mlb_ctrl
    import mlb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      func,
    input  mlb_stat_t stat,
    output mlb_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Decode commands for the datapath
    always_comb
    begin
        cmd.measure    = accept && !func;
        cmd.bin_live   = accept && func && stat.in_binarize;
        cmd.level_load = accept && func && !stat.in_binarize;
        cmd.bin_held   = state_reg == ST_FINISH;
    end

    // Advance the sequencer: latch the level once per pass, then finish the held pixel
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.level_load)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = state_next != ST_IDLE;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    `MLB_ASSERT_NEXT(a_first_bin_busy, clk, rst_n, cmd.level_load,
                     busy && state_reg == ST_FINISH, "first binarize transaction not held")
    `MLB_ASSERT_NEXT(a_finish_release, clk, rst_n, state_reg == ST_FINISH, !busy,
                     "busy held after the held pixel finished")
    `MLB_ASSERT_NOW(a_no_accept_busy, clk, rst_n, busy,
                    !(cmd.measure || cmd.bin_live || cmd.level_load),
                    "transaction accepted while busy")
    `MLB_ASSERT_NOW(a_busy_matches_state, clk, rst_n, 1'b1, busy == (state_reg != ST_IDLE),
                    "busy disagrees with the sequencer state")

endmodule

>>> rtl/mean_luma_binarizer_core.sv
`timescale 1ns / 1ps
// A measure transaction gives no result; a binarize transaction gives its result strobe
//   in the cycle after it is accepted.
// The first binarize transaction of a pass latches the level from the sum and holds its
//   pixel in the finish state, where busy is high; its result strobe is registered from that state.
// Throughput: 1 transaction per cycle otherwise; results are never stalled by the receiver.
// Reset (async, active low): bias 1, sum and level zero, packer empty, measure pass.

module mean_luma_binarizer_core
    import mlb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                threshold_bias_we,
    input  logic [BIAS_W-1:0]   threshold_bias_wdata,
    output logic                done,
    output logic                white,
    output logic [BYTE_W-1:0]   packed_byte,
    output logic                byte_ready,
    output logic [LEVEL_W-1:0]  level
);

    mlb_cmd_t  cmd;
    mlb_stat_t stat;

    // Sequence the passes and the level latch
    mlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Sum, divide, compare and pack
    mlb_dpath u_dpath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .pixel                (pixel),
        .threshold_bias_we    (threshold_bias_we),
        .threshold_bias_wdata (threshold_bias_wdata),
        .done                 (done),
        .white                (white),
        .packed_byte          (packed_byte),
        .byte_ready           (byte_ready),
        .level                (level)
    );

endmodule

>>> bench/mlb_tb_pkg.sv
`timescale 1ns / 1ps

package mlb_tb_pkg;

    // Pass selector carried by each pixel transaction
    typedef enum logic {
        FUNC_MEASURE   = 1'b0,
        FUNC_BINARIZE  = 1'b1
    } pass_func_t;

endpackage

>>> bench/luma_threshold_checker.sv
`timescale 1ns / 1ps

module luma_threshold_checker
    import mlb_pkg::*;
    import mlb_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                func,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                threshold_bias_we,
    input  logic [BIAS_W-1:0]   threshold_bias_wdata,
    input  logic                done,
    input  logic                white,
    input  logic [BYTE_W-1:0]   packed_byte,
    input  logic                byte_ready,
    input  logic [LEVEL_W-1:0]  level,
    output int                  fail_count,
    output int                  pending
);

    localparam int unsigned SUM_LIMIT = (1 << SUM_W) - 1;
    localparam int unsigned LEVEL_TOP = (1 << LEVEL_W) - 1;
    localparam int          PRINT_CAP = 40;

    typedef struct packed {
        logic               white;
        logic [BYTE_W-1:0]  bits;
        logic               ready;
        logic [LEVEL_W-1:0] level;
    } binarized_pixel_t;

    binarized_pixel_t expected_pixels[$];

    // Shadow copy of the block's state and its bias register
    logic [BIAS_W-1:0]  bias_now;
    logic [SUM_W-1:0]   luma_total;
    logic [LEVEL_W-1:0] frame_level;
    logic [BYTE_W-1:0]  byte_bits;
    logic [SLOT_W-1:0]  slot;
    logic               binarizing;
    int unsigned        column;
    int                 mismatches = 0;

    function automatic int unsigned weighted_luma(input logic [PIXEL_W-1:0] px);
        int unsigned red;
        int unsigned green;
        int unsigned blue;
        red   = px[15:11];
        // only the top five bits of the six-bit green field count
        green = px[10:6];
        blue  = px[4:0];
        return red * COEF_R + green * COEF_G + blue * COEF_B;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_packer();
        byte_bits = '0;
        slot      = '0;
        column    = 0;
    endtask

    // Advance the shadow state by one accepted pixel transaction
    task automatic predict_pixel(input logic item_func, input logic [PIXEL_W-1:0] px);
        int unsigned      luma;
        int unsigned      total;
        int unsigned      mean;
        int unsigned      cutoff;
        binarized_pixel_t outcome;
        luma = weighted_luma(px);
        if (item_func == FUNC_MEASURE) begin
            // a measure pixel after a binarize pixel opens a new frame
            if (binarizing) begin
                binarizing = 1'b0;
                luma_total = '0;
                clear_packer();
            end
            total      = luma_total + (luma >> FRAC_W);
            luma_total = SUM_W'(total > SUM_LIMIT ? SUM_LIMIT : total);
        end
        else begin
            // latch the level on the first pixel of the binarize pass
            if (!binarizing) begin
                mean        = luma_total / FRAME_PIXELS;
                frame_level = LEVEL_W'(mean > LEVEL_TOP ? LEVEL_TOP : mean);
                binarizing  = 1'b1;
                clear_packer();
            end
            cutoff        = (int'(frame_level) + int'(bias_now)) << FRAC_W;
            outcome.white = (luma > cutoff);
            byte_bits     = byte_bits | (BYTE_W'(outcome.white) << slot);
            outcome.bits  = byte_bits;
            outcome.ready = (slot == SLOT_W'(BYTE_W - 1));
            outcome.level = frame_level;
            expected_pixels.push_back(outcome);
            if (outcome.ready)
                byte_bits = '0;
            // the slot follows the column, which wraps at the line end
            if (column + 1 >= LINE_PIXELS) begin
                column = 0;
                slot   = '0;
            end
            else begin
                column++;
                slot = SLOT_W'(column);
            end
        end
    endtask

    // Compare one result strobe with the oldest expectation
    task automatic check_result();
        binarized_pixel_t want;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: white %0d byte %02h ready %0d level %0d",
                                      white, packed_byte, byte_ready, level));
        end
        else begin
            want = expected_pixels.pop_front();
            if (white !== want.white)
                report_mismatch($sformatf("white got %0d expected %0d", white, want.white));
            if (packed_byte !== want.bits)
                report_mismatch($sformatf("packed_byte got %02h expected %02h",
                                          packed_byte, want.bits));
            if (byte_ready !== want.ready)
                report_mismatch($sformatf("byte_ready got %0d expected %0d",
                                          byte_ready, want.ready));
            if (level !== want.level)
                report_mismatch($sformatf("level got %0d expected %0d", level, want.level));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bias_now    = BIAS_W'(1);
            luma_total  = '0;
            frame_level = '0;
            binarizing  = 1'b0;
            clear_packer();
            expected_pixels.delete();
        end
        else begin
            // Take a bias write
            if (threshold_bias_we)
                bias_now = threshold_bias_wdata;
            // Check results before predicting the transaction of this edge
            if (done)
                check_result();
            if (start && !busy)
                predict_pixel(func, pixel);
        end
        fail_count <= mismatches;
        pending    <= expected_pixels.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mlb_pkg::*;
    import mlb_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int TOTAL_ITEMS   = 600;
    localparam int SETTLE_CYCLES = 12;

    typedef enum int {
        PX_ANY,
        PX_GRAY,
        PX_CAPPED,
        PX_BRIGHT
    } pixel_mode_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                func;
    logic [PIXEL_W-1:0]  pixel;
    logic                threshold_bias_we;
    logic [BIAS_W-1:0]   threshold_bias_wdata;
    logic                done;
    logic                white;
    logic [BYTE_W-1:0]   packed_byte;
    logic                byte_ready;
    logic [LEVEL_W-1:0]  level;

    int fail_count;
    int pending;
    int cycles = 0;
    int items_sent = 0;

    mean_luma_binarizer_core uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .pixel                (pixel),
        .threshold_bias_we    (threshold_bias_we),
        .threshold_bias_wdata (threshold_bias_wdata),
        .done                 (done),
        .white                (white),
        .packed_byte          (packed_byte),
        .byte_ready           (byte_ready),
        .level                (level)
    );

    luma_threshold_checker watch (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .pixel                (pixel),
        .threshold_bias_we    (threshold_bias_we),
        .threshold_bias_wdata (threshold_bias_wdata),
        .done                 (done),
        .white                (white),
        .packed_byte          (packed_byte),
        .byte_ready           (byte_ready),
        .level                (level),
        .fail_count           (fail_count),
        .pending              (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL mean_luma_binarizer_core");
            $finish;
        end
    end

    function automatic logic [PIXEL_W-1:0] gray_pixel(input logic [4:0] k, input logic g_lsb);
        return {k, k, g_lsb, k};
    endfunction

    function automatic logic [PIXEL_W-1:0] make_pixel(input pixel_mode_t mode,
                                                      input int unsigned cap);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        r = 5'($urandom_range(0, cap));
        g = 5'($urandom_range(0, cap));
        b = 5'($urandom_range(0, cap));
        case (mode)
            PX_GRAY:   return gray_pixel(5'($urandom_range(0, 31)), 1'($urandom));
            PX_CAPPED: return {r, g, 1'($urandom), b};
            // full-scale luma, only the unused green bit varies
            PX_BRIGHT: return {10'h3FF, 1'($urandom), 5'h1F};
            default:   return PIXEL_W'($urandom);
        endcase
    endfunction

    // Hold start until the block takes the transaction
    task automatic send_item(input pass_func_t f, input logic [PIXEL_W-1:0] px);
        start <= 1'b1;
        func  <= f;
        pixel <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop start for a random gap, scrambling the idle payload
    task automatic idle_gap(input bit quiet);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (quiet)
            n = (pick == 0) ? $urandom_range(1, 3) : 0;
        else if (pick < 55)
            n = 0;
        else if (pick < 85)
            n = $urandom_range(1, 3);
        else if (pick < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 50);
        if (n > 0)
        begin
            start <= 1'b0;
            func  <= 1'($urandom);
            pixel <= PIXEL_W'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Write the bias only once the block has gone quiet
    task automatic write_bias(input logic [BIAS_W-1:0] value);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        threshold_bias_we    <= 1'b1;
        threshold_bias_wdata <= value;
        @(posedge clk);
        threshold_bias_we    <= 1'b0;
    endtask

    task automatic measure_pass(input int n, input pixel_mode_t mode, input int unsigned cap,
                                input bit quiet);
        repeat (n)
        begin
            send_item(FUNC_MEASURE, make_pixel(mode, cap));
            idle_gap(quiet);
        end
    endtask

    task automatic binarize_pass(input int n, input bit quiet);
        repeat (n)
        begin
            send_item(FUNC_BINARIZE,
                      make_pixel(pixel_mode_t'($urandom_range(0, 3)), $urandom_range(0, 31)));
            idle_gap(quiet);
        end
    endtask

    initial
    begin
        int  n;
        bit  quiet;
        logic [BIAS_W-1:0] bias_pick;

        rst_n                <= 1'b0;
        start                <= 1'b0;
        func                 <= FUNC_MEASURE;
        pixel                <= '0;
        threshold_bias_we    <= 1'b0;
        threshold_bias_wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Binarize straight after reset: level 0, bias 1, gray 1 sits on the threshold
        send_item(FUNC_BINARIZE, gray_pixel(5'd0, 1'b0));
        send_item(FUNC_BINARIZE, gray_pixel(5'd1, 1'b0));
        send_item(FUNC_BINARIZE, gray_pixel(5'd2, 1'b0));
        send_item(FUNC_BINARIZE, 16'hFFFF);
        send_item(FUNC_BINARIZE, 16'h0020);
        send_item(FUNC_BINARIZE, 16'hF800);
        send_item(FUNC_BINARIZE, 16'h07E0);
        send_item(FUNC_BINARIZE, 16'h001F);

        // Start a new measure pass, then a new binarize pass
        send_item(FUNC_MEASURE, 16'hFFFF);
        send_item(FUNC_MEASURE, 16'h0000);
        send_item(FUNC_BINARIZE, gray_pixel(5'd1, 1'b1));
        send_item(FUNC_BINARIZE, 16'hFFFF);

        // Bias extremes inside a running pass
        write_bias(5'd0);
        send_item(FUNC_BINARIZE, gray_pixel(5'd0, 1'b1));
        send_item(FUNC_BINARIZE, gray_pixel(5'd1, 1'b0));
        write_bias(5'd31);
        send_item(FUNC_BINARIZE, 16'hFFFF);
        send_item(FUNC_BINARIZE, gray_pixel(5'd31, 1'b0));
        send_item(FUNC_MEASURE, 16'hFFDF);
        send_item(FUNC_BINARIZE, 16'h0000);

        // One binarize pass longer than a line, so the column wraps
        write_bias(5'd0);
        measure_pass(16, PX_BRIGHT, 0, 1'b0);
        binarize_pass(LINE_PIXELS + 12, 1'b0);

        // Random frames, mostly short, with mixed-pass noise now and then
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       bias_pick = 5'd0;
                    1:       bias_pick = 5'd31;
                    default: bias_pick = 5'($urandom_range(0, 31));
                endcase
                write_bias(bias_pick);
            end
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(10, 30))
                begin
                    send_item(pass_func_t'($urandom_range(0, 1)), PIXEL_W'($urandom));
                    idle_gap(quiet);
                end
            end
            else
            begin
                measure_pass($urandom_range(0, 16), PX_ANY, 31, quiet);
                n = $urandom_range(1, 40);
                binarize_pass(n, quiet);
            end
        end

        // Drain outstanding results, then give the verdict
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS mean_luma_binarizer_core");
        else
            $display("FAIL mean_luma_binarizer_core");
        $finish;
    end

endmodule
